// ----- src/mtg_pkg.sv -----
// ---------------------------------------------------------------------------
// mtg_pkg
// Shared constants, types and word functions for the MT19937 generator.
// ---------------------------------------------------------------------------
`default_nettype none

package mtg_pkg;

   localparam int WORDS      = 624;
   localparam int SHIFT_DIST = 397;
   localparam int IDX_W      = 10;

   localparam logic [IDX_W-1:0] IDX_FULL  = IDX_W'(WORDS);
   localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(WORDS - 1);
   localparam logic [IDX_W-1:0] IDX_SHIFT = IDX_W'(SHIFT_DIST);
   localparam logic [IDX_W-1:0] IDX_WRAP  = IDX_W'(WORDS - SHIFT_DIST);

   localparam logic [31:0] TWIST_XOR    = 32'h9908_b0df;
   localparam logic [31:0] HIGH_BIT     = 32'h8000_0000;
   localparam logic [31:0] LOW_BITS     = 32'h7fff_ffff;
   localparam logic [31:0] TEMPER_B     = 32'h9d2c_5680;
   localparam logic [31:0] TEMPER_C     = 32'hefc6_0000;
   localparam logic [31:0] SEED_MULT    = 32'd1812433253;
   localparam logic [31:0] DEFAULT_SEED = 32'd5489;

   localparam logic KIND_DRAW   = 1'b0;
   localparam logic KIND_RESEED = 1'b1;

   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      logic [31:0]      wr_data;
      logic [IDX_W-1:0] rd_addr;
   } mem_req_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] word;
   } result_type;

   function automatic logic [31:0] twist_word(input logic [31:0] cur,
                                              input logic [31:0] nxt,
                                              input logic [31:0] far);
      logic [31:0] y;
      logic [31:0] v;
      y = (cur & HIGH_BIT) | (nxt & LOW_BITS);
      v = far ^ (y >> 1);
      if (y[0]) begin
         v = v ^ TWIST_XOR;
      end
      return v;
   endfunction

   function automatic logic [31:0] temper(input logic [31:0] w);
      logic [31:0] y;
      y = w;
      y = y ^ (y >> 11);
      y = y ^ ((y << 7) & TEMPER_B);
      y = y ^ ((y << 15) & TEMPER_C);
      y = y ^ (y >> 18);
      return y;
   endfunction

endpackage

`default_nettype wire

// ----- src/mersenne_twister_generator.sv -----
// ---------------------------------------------------------------------------
// mersenne_twister_generator
// MT19937 32-bit generator with in-memory state and per-word twisting.
// ---------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid / req_stall): req_kind draw or reseed, with
//   req_seed_value used on reseed. Response channel (rsp_valid / rsp_stall)
//   carries one tempered rsp_random_word per draw; a reseed gives nothing.
//   One request is in work at a time; req_stall is high while busy.
//   Draw: reads the word, its neighbour and the word 397 on from a single
//   read port, twists and writes back; the tempered result then sits in the
//   output register.
//   Reseed: the seed recurrence writes one word a cycle, 624 words in all.
//   After reset the generator is unseeded; the first draw seeds with 5489
//   first and then twists the word for that draw.
//   If rsp_stall holds a waiting result, a finished draw waits in the
//   sequencer until the output register frees; no request is dropped.
// ---------------------------------------------------------------------------
`default_nettype none

module mersenne_twister_generator (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_kind,
   input  wire logic [31:0] req_seed_value,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_random_word
);
   import mtg_pkg::*;

   mem_req_type mem_req;
   result_type  result;
   logic [31:0] rd_data;
   logic        out_ready;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_word_ff, rsp_word_in;

   assign out_ready = !rsp_valid_ff || !rsp_stall;

   mtg_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_kind       (req_kind),
      .req_seed_value (req_seed_value),
      .req_stall      (req_stall),
      .out_ready      (out_ready),
      .result         (result),
      .mem_req        (mem_req),
      .rd_data        (rd_data)
   );

   mtg_ram u_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (out_ready) begin
         rsp_valid_in = result.valid;
         if (result.valid) begin
            rsp_word_in = temper(result.word);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_random_word = rsp_word_ff;

endmodule

`default_nettype wire

// ----- src/mtg_ram.sv -----
// ---------------------------------------------------------------------------
// mtg_ram
// 624 x 32 state memory: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module mtg_ram (
   input  wire logic                 clock,
   input  wire mtg_pkg::mem_req_type mem_req,
   output logic [31:0]               rd_data
);
   import mtg_pkg::*;

   logic [31:0] mem [WORDS];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      rd_data_ff <= mem[mem_req.rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- src/mtg_ctrl.sv -----
// ---------------------------------------------------------------------------
// mtg_ctrl
// Sequencer: seeds the state memory and twists one word per draw.
// ---------------------------------------------------------------------------
`default_nettype none

module mtg_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_kind,
   input  wire logic [31:0]          req_seed_value,
   output logic                      req_stall,
   input  wire logic                 out_ready,
   output mtg_pkg::result_type       result,
   output mtg_pkg::mem_req_type      mem_req,
   input  wire logic [31:0]          rd_data
);
   import mtg_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SEED = 3'd1;
   localparam logic [2:0] S_RD_K = 3'd2;
   localparam logic [2:0] S_RD_N = 3'd3;
   localparam logic [2:0] S_RD_F = 3'd4;
   localparam logic [2:0] S_TW   = 3'd5;
   localparam logic [2:0] S_DONE = 3'd6;

   logic [2:0]       state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] k_ff, k_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic             pend_ff, pend_in;
   logic [31:0]      prev_ff, prev_in;
   logic [31:0]      cur_ff, cur_in;
   logic [31:0]      nxt_ff, nxt_in;
   logic [31:0]      word_ff, word_in;
   logic [31:0]      seed_word;
   logic [31:0]      twisted;
   logic [IDX_W-1:0] next_addr;
   logic [IDX_W-1:0] far_addr;

   assign seed_word = (SEED_MULT * (prev_ff ^ (prev_ff >> 30))) + {22'd0, cnt_ff};
   assign twisted   = twist_word(cur_ff, nxt_ff, rd_data);
   assign next_addr = (k_ff == IDX_LAST) ? '0 : k_ff + 1'b1;
   // far neighbour wraps into words already twisted this round
   assign far_addr  = (k_ff < IDX_WRAP) ? k_ff + IDX_SHIFT : k_ff - IDX_WRAP;

   assign req_stall    = (state_ff != S_IDLE);
   assign result.valid = (state_ff == S_DONE);
   assign result.word  = word_ff;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      k_in     = k_ff;
      cnt_in   = cnt_ff;
      pend_in  = pend_ff;
      prev_in  = prev_ff;
      cur_in   = cur_ff;
      nxt_in   = nxt_ff;
      word_in  = word_ff;
      mem_req  = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_kind == KIND_RESEED || idx_ff > IDX_FULL) begin
                  // reseed, or a never-seeded draw, which seeds with the default first
                  mem_req.wr_en   = 1'b1;
                  mem_req.wr_addr = '0;
                  mem_req.wr_data = (req_kind == KIND_RESEED) ? req_seed_value
                                                              : DEFAULT_SEED;
                  prev_in  = mem_req.wr_data;
                  cnt_in   = IDX_W'(1);
                  idx_in   = IDX_FULL;
                  k_in     = '0;
                  pend_in  = (req_kind == KIND_DRAW);
                  state_in = S_SEED;
               end else begin
                  k_in     = (idx_ff == IDX_FULL) ? '0 : idx_ff;
                  state_in = S_RD_K;
               end
            end
         end
         S_SEED: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = cnt_ff;
            mem_req.wr_data = seed_word;
            prev_in = seed_word;
            if (cnt_ff == IDX_LAST) begin
               pend_in  = 1'b0;
               state_in = pend_ff ? S_RD_K : S_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_RD_K: begin
            mem_req.rd_addr = k_ff;
            state_in = S_RD_N;
         end
         S_RD_N: begin
            mem_req.rd_addr = next_addr;
            cur_in   = rd_data;
            state_in = S_RD_F;
         end
         S_RD_F: begin
            mem_req.rd_addr = far_addr;
            nxt_in   = rd_data;
            state_in = S_TW;
         end
         S_TW: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = k_ff;
            mem_req.wr_data = twisted;
            word_in  = twisted;
            idx_in   = k_ff + 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= IDX_W'(WORDS + 1);
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff    <= k_in;
      cnt_ff  <= cnt_in;
      prev_ff <= prev_in;
      cur_ff  <= cur_in;
      nxt_ff  <= nxt_in;
      word_ff <= word_in;
   end

endmodule

`default_nettype wire
